### rtl/apse_pkg.sv
// ---------------------------------------------------------------------------
// apse_pkg
// Shared types and constants of the actuator position and speed estimator.
// ---------------------------------------------------------------------------
package apse_pkg;

   localparam int SUM_W    = 24;
   localparam int CNT_W    = 6;
   localparam int TEN_W    = 10;
   localparam int TICK_W   = 32;
   localparam int SAMPLE_W = 18;
   localparam int AXIS_W   = 2;
   localparam int CSR_IDX_W = 2;

   // divider geometry: 16-bit dividend, 32-bit divisor
   localparam int DIV_N_W = 16;
   localparam int DIV_D_W = 32;

   // sum * POS_SCALE / (WINDOW * 2^16) gives tenths of a millimetre
   localparam int POS_SCALE = 250;
   localparam int FRAC_W    = 16;

   localparam logic [TEN_W-1:0] TEN_MAX = '1;

   // zone codes
   localparam logic [1:0] ZONE_COMBINE  = 2'd0;
   localparam logic [1:0] ZONE_SEPARATE = 2'd1;
   localparam logic [1:0] ZONE_MIDDLE   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COMBINE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_W   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 2'd3;

   // register reset values
   localparam logic [TEN_W-1:0] RST_COMBINE  = 10'd450;
   localparam logic [TEN_W-1:0] RST_SEPARATE = 10'd200;
   localparam logic [TEN_W-1:0] RST_HALF_W   = 10'd10;
   localparam logic [TEN_W-1:0] RST_LIMIT    = 10'd80;

   // per-axis state entry
   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]  count;
      logic [TEN_W-1:0]  prev_pos;
      logic [TICK_W-1:0] prev_tick;
      logic [TEN_W-1:0]  speed;
   } entry_type;

   // divider command and status
   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/apse_state_mem.sv
// ---------------------------------------------------------------------------
// apse_state_mem
// Per-axis state memory, registered read, valid bits for reset.
// ---------------------------------------------------------------------------
module apse_state_mem #(
   parameter int DEPTH = 2,
   parameter int AW    = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output apse_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  apse_pkg::entry_type wr_data
);

   apse_pkg::entry_type mem [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   apse_pkg::entry_type rd_data_ff;
   logic                rd_valid_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // valid bits: a never-written entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### rtl/apse_divider.sv
// ---------------------------------------------------------------------------
// apse_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module apse_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  apse_pkg::div_cmd_type cmd,
   output apse_pkg::div_rsp_type status
);

   localparam int N  = apse_pkg::DIV_N_W;
   localparam int D  = apse_pkg::DIV_D_W;
   localparam int CW = $clog2(N + 1);

   logic [D-1:0]  rem_ff;
   logic [N-1:0]  dq_ff;
   logic [D-1:0]  dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;

   logic [D:0]    shifted;
   logic          fits;
   logic [D:0]    diff;

   // one trial subtraction
   always_comb begin
      shifted = {rem_ff, dq_ff[N-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            rem_ff  <= '0;
            dq_ff   <= cmd.dividend;
            dvs_ff  <= cmd.divisor;
            cnt_ff  <= CW'(N);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[D-1:0] : shifted[D-1:0];
            dq_ff  <= {dq_ff[N-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.done     = done_ff;
   assign status.quotient = dq_ff;

endmodule

### rtl/actuator_position_speed_estimator.sv
// ---------------------------------------------------------------------------
// actuator_position_speed_estimator
// Per-axis window averaging of position samples with zone and speed output.
// ---------------------------------------------------------------------------
// An accumulating transaction holds the block for the state memory read, then
// the write back; a rejected transaction does not hold the block.
// A window-closing transaction runs through LOOK, DIVP, CALC, CHECK and FINISH,
// adding DIVS when the speed is accepted and the serial divider runs; result
// stalls hold FINISH. No new transaction is taken until the block is idle again.
// Reset is synchronous: registers reload defaults, axis state reads as zero.
module actuator_position_speed_estimator #(
   parameter int AXES   = 2,
   parameter int WINDOW = 50
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [apse_pkg::AXIS_W-1:0]       req_axis,
   input  logic [apse_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                              req_sensor_fault,
   input  logic [apse_pkg::TICK_W-1:0]       req_tick,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_axis_out,
   output logic [apse_pkg::TEN_W-1:0]        rsp_position_tenths,
   output logic [1:0]                        rsp_zone,
   output logic [apse_pkg::TEN_W-1:0]        rsp_speed_tenths,
   output logic                              rsp_speed_updated,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [apse_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [apse_pkg::TEN_W-1:0]        csr_wdata
);

   localparam int AW    = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int TW    = apse_pkg::TEN_W;
   localparam int PW    = TW + apse_pkg::TICK_W;
   localparam int SUM_W = apse_pkg::SUM_W;
   localparam int NW    = apse_pkg::DIV_N_W;

   // reciprocal of the window length, exact for 16-bit numerators
   localparam int     RECIP_SH = apse_pkg::FRAC_W + $clog2(WINDOW);
   localparam longint RECIP    = ((longint'(1) << RECIP_SH) + longint'(WINDOW) - 1)
                                 / longint'(WINDOW);
   localparam int     MW       = 40;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DIVP,
      ST_CALC,
      ST_CHECK,
      ST_DIVS,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [TW-1:0] combine_ff;
   logic [TW-1:0] separate_ff;
   logic [TW-1:0] half_w_ff;
   logic [TW-1:0] limit_ff;

   // transaction and working registers
   logic [AW-1:0]                   ax_ff;
   logic [apse_pkg::SAMPLE_W-1:0]   sample_ff;
   logic [apse_pkg::TICK_W-1:0]     tick_ff;
   apse_pkg::entry_type             entry_ff;
   logic [NW-1:0]                   mean_num_ff;
   logic [TW-1:0]                   pos_ff;
   logic [1:0]                      zone_ff;
   logic [TW-1:0]                   dpos_ff;
   logic [apse_pkg::TICK_W-1:0]     dticks_ff;
   logic [TW-1:0]                   speed_ff;
   logic                            upd_ff;

   // result register
   logic                            rsp_valid_ff;
   logic                            rsp_axis_ff;
   logic [TW-1:0]                   rsp_pos_ff;
   logic [1:0]                      rsp_zone_ff;
   logic [TW-1:0]                   rsp_speed_ff;
   logic                            rsp_upd_ff;

   // combinational
   logic                            accept;
   logic                            axis_ok;
   logic                            good;
   logic                            below_full;
   logic [31:0]                     scaled;
   logic                            out_free;
   logic [TW:0]                     c_hi, c_lo_chk, s_hi, s_lo_chk, pos_hw;
   logic [1:0]                      zone_in;
   logic [TW-1:0]                   dpos_in;
   logic [PW-1:0]                   limit_prod;
   logic                            speed_ok;
   logic [MW-1:0]                   mean_prod;
   logic [NW-1:0]                   mean_q;
   logic [TW-1:0]                   pos_sat_in;

   apse_pkg::entry_type             rd_entry;
   apse_pkg::entry_type             wr_entry;
   logic                            mem_wr_en;
   apse_pkg::div_cmd_type           div_cmd;
   apse_pkg::div_rsp_type           div_status;

   // handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign axis_ok   = {1'b0, req_axis} < 3'(AXES);
   assign good      = accept && axis_ok && !req_sensor_fault;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // window fill and scaled sum
   assign below_full = {1'b0, rd_entry.count} < 7'(WINDOW);
   assign scaled     = 32'(rd_entry.sum) * 32'(apse_pkg::POS_SCALE);

   // saturated mean position by reciprocal multiplication
   assign mean_prod  = MW'(mean_num_ff) * MW'(RECIP);
   assign mean_q     = mean_prod[RECIP_SH +: NW];
   assign pos_sat_in = (mean_q > NW'(apse_pkg::TEN_MAX))
                       ? apse_pkg::TEN_MAX : mean_q[TW-1:0];

   // zone windows, strict on both sides
   always_comb begin
      pos_hw   = {1'b0, pos_ff} + {1'b0, half_w_ff};
      c_hi     = {1'b0, combine_ff} + {1'b0, half_w_ff};
      s_hi     = {1'b0, separate_ff} + {1'b0, half_w_ff};
      c_lo_chk = {1'b0, combine_ff};
      s_lo_chk = {1'b0, separate_ff};
      if (({1'b0, pos_ff} < c_hi) && (pos_hw > c_lo_chk)) begin
         zone_in = apse_pkg::ZONE_COMBINE;
      end else if (({1'b0, pos_ff} < s_hi) && (pos_hw > s_lo_chk)) begin
         zone_in = apse_pkg::ZONE_SEPARATE;
      end else begin
         zone_in = apse_pkg::ZONE_MIDDLE;
      end
   end

   assign dpos_in = (pos_ff >= entry_ff.prev_pos) ? (pos_ff - entry_ff.prev_pos)
                                                  : (entry_ff.prev_pos - pos_ff);

   // speed limit check
   assign limit_prod = PW'(limit_ff) * PW'(dticks_ff);
   assign speed_ok   = (dticks_ff != '0) && (PW'(dpos_ff) < limit_prod);

   // divider command: speed only
   always_comb begin
      div_cmd.start    = (state_ff == ST_CHECK) && speed_ok;
      div_cmd.dividend = NW'(dpos_ff);
      div_cmd.divisor  = dticks_ff;
   end

   // state write back
   always_comb begin
      mem_wr_en = 1'b0;
      wr_entry  = rd_entry;
      if (state_ff == ST_LOOK && below_full) begin
         mem_wr_en      = 1'b1;
         wr_entry.sum   = rd_entry.sum + SUM_W'(sample_ff);
         wr_entry.count = rd_entry.count + 1'b1;
      end else if (state_ff == ST_FINISH) begin
         mem_wr_en          = out_free;
         wr_entry.sum       = '0;
         wr_entry.count     = '0;
         wr_entry.prev_pos  = pos_ff;
         wr_entry.prev_tick = tick_ff;
         wr_entry.speed     = speed_ff;
      end
   end

   apse_state_mem #(
      .DEPTH (AXES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (good),
      .rd_addr (req_axis[AW-1:0]),
      .rd_data (rd_entry),
      .wr_en   (mem_wr_en),
      .wr_addr (ax_ff),
      .wr_data (wr_entry)
   );

   apse_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .status (div_status)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         combine_ff  <= apse_pkg::RST_COMBINE;
         separate_ff <= apse_pkg::RST_SEPARATE;
         half_w_ff   <= apse_pkg::RST_HALF_W;
         limit_ff    <= apse_pkg::RST_LIMIT;
      end else if (csr_wr_en) begin
         case (csr_index)
            apse_pkg::CSR_COMBINE:  combine_ff  <= csr_wdata;
            apse_pkg::CSR_SEPARATE: separate_ff <= csr_wdata;
            apse_pkg::CSR_HALF_W:   half_w_ff   <= csr_wdata;
            apse_pkg::CSR_LIMIT:    limit_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (good) begin
                  ax_ff     <= req_axis[AW-1:0];
                  sample_ff <= req_sample;
                  tick_ff   <= req_tick;
                  state_ff  <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               entry_ff    <= rd_entry;
               mean_num_ff <= scaled[31:apse_pkg::FRAC_W];
               state_ff    <= below_full ? ST_IDLE : ST_DIVP;
            end
            ST_DIVP: begin
               pos_ff   <= pos_sat_in;
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               zone_ff   <= zone_in;
               dpos_ff   <= dpos_in;
               dticks_ff <= tick_ff - entry_ff.prev_tick;
               state_ff  <= ST_CHECK;
            end
            ST_CHECK: begin
               if (speed_ok) begin
                  state_ff <= ST_DIVS;
               end else begin
                  speed_ff <= entry_ff.speed;
                  upd_ff   <= 1'b0;
                  state_ff <= ST_FINISH;
               end
            end
            ST_DIVS: begin
               if (div_status.done) begin
                  speed_ff <= div_status.quotient[TW-1:0];
                  upd_ff   <= 1'b1;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_axis_ff  <= ax_ff[0];
                  rsp_pos_ff   <= pos_ff;
                  rsp_zone_ff  <= zone_ff;
                  rsp_speed_ff <= speed_ff;
                  rsp_upd_ff   <= upd_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_axis_out        = rsp_axis_ff;
   assign rsp_position_tenths = rsp_pos_ff;
   assign rsp_zone            = rsp_zone_ff;
   assign rsp_speed_tenths    = rsp_speed_ff;
   assign rsp_speed_updated   = rsp_upd_ff;

endmodule

### rtl/apse_checker.sv
// ---------------------------------------------------------------------------
// apse_checker
// Port-level checks of the estimator, bound to the top level.
// ---------------------------------------------------------------------------
module apse_checker #(
   parameter int AXES = 2
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [apse_pkg::AXIS_W-1:0]       req_axis,
   input logic                              req_sensor_fault,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [apse_pkg::TEN_W-1:0]        rsp_position_tenths,
   input logic [1:0]                        rsp_zone
);

   logic good_txn;
   logic drop_txn;

   assign good_txn = req_valid && !req_stall && ({1'b0, req_axis} < 3'(AXES))
                     && !req_sensor_fault;
   assign drop_txn = req_valid && !req_stall && !good_txn;

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a good transaction always occupies the state memory cycle
   a_good_busy: assert property (@(posedge clock) disable iff (reset)
      good_txn |=> req_stall)
      else $error("no stall after good transaction");

   // a dropped transaction leaves the block free
   a_drop_free: assert property (@(posedge clock) disable iff (reset)
      drop_txn |=> !req_stall)
      else $error("stall after dropped transaction");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_position_tenths)))
      else $error("stalled result changed");

   // zone code is one of the three zones
   a_zone_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zone == apse_pkg::ZONE_COMBINE ||
                     rsp_zone == apse_pkg::ZONE_SEPARATE ||
                     rsp_zone == apse_pkg::ZONE_MIDDLE))
      else $error("bad zone code");

endmodule

bind actuator_position_speed_estimator apse_checker #(.AXES(AXES)) u_apse_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_axis            (req_axis),
   .req_sensor_fault    (req_sensor_fault),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_position_tenths (rsp_position_tenths),
   .rsp_zone            (rsp_zone)
);
